// ===== rtl/frs_pkg.sv =====
package frs_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int CMD_W      = 2;
    localparam int IDEAL_W    = 20;
    localparam int FRAME_W    = 24;
    localparam int COUNT_W    = 32;
    localparam int SUM_W      = 48;
    localparam int JIT_W      = 64;
    localparam int OUT_W      = 36;
    localparam int MICROS_W   = 20;
    localparam int PROD_W     = COUNT_W + MICROS_W;
    localparam int NUM_W      = PROD_W + FRAC_BITS;
    localparam int DIV_W      = SUM_W;
    localparam int RATE_W     = MICROS_W + FRAC_BITS;
    localparam int STEP_W     = $clog2(NUM_W + 1);

    localparam logic [MICROS_W-1:0] MICROS_PER_SEC = MICROS_W'(1000000);
    localparam logic [IDEAL_W-1:0]  IDEAL_RESET    = IDEAL_W'(16667);

    // 1e6 scaled to fixed point, left aligned in the divider numerator
    localparam logic [NUM_W-1:0] RATE_NUM_AL =
        NUM_W'(MICROS_PER_SEC) << (NUM_W - MICROS_W);
    localparam logic [STEP_W-1:0] RATE_STEPS = STEP_W'(RATE_W);
    localparam logic [STEP_W-1:0] FULL_STEPS = STEP_W'(NUM_W);

    localparam logic [CMD_W-1:0] CMD_FRAME  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REPORT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  numer;
        logic [DIV_W-1:0]  divisor;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_WAIT_A   = 9'b000000010,
        ST_WAIT_B   = 9'b000000100,
        ST_MUL      = 9'b000001000,
        ST_WAIT_AVG = 9'b000010000,
        ST_WAIT_MIN = 9'b000100000,
        ST_WAIT_MAX = 9'b001000000,
        ST_WAIT_JIT = 9'b010000000,
        ST_DONE     = 9'b100000000
    } state_t;

endpackage

// ===== rtl/frs_div.sv =====
// Restoring divider, one quotient bit per cycle, quotient saturated to OUT_W bits.
module frs_div
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  frs_pkg::div_req_t               req,
    output logic                            done,
    output logic [frs_pkg::OUT_W-1:0]       quotient
);

    logic [frs_pkg::NUM_W-1:0]  num_reg;
    logic [frs_pkg::DIV_W-1:0]  den_reg;
    logic [frs_pkg::DIV_W-1:0]  rem_reg;
    logic [frs_pkg::OUT_W-1:0]  quo_reg;
    logic                       over_reg;
    logic [frs_pkg::STEP_W-1:0] cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [frs_pkg::DIV_W:0]    rem_sh;
    logic                       fits;

    assign rem_sh = {rem_reg, num_reg[frs_pkg::NUM_W-1]};
    assign fits   = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == frs_pkg::STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg  <= req.numer;
            den_reg  <= req.divisor;
            rem_reg  <= '0;
            quo_reg  <= '0;
            over_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            num_reg  <= {num_reg[frs_pkg::NUM_W-2:0], 1'b0};
            rem_reg  <= fits ? frs_pkg::DIV_W'(rem_sh - {1'b0, den_reg})
                             : frs_pkg::DIV_W'(rem_sh);
            quo_reg  <= {quo_reg[frs_pkg::OUT_W-2:0], fits};
            over_reg <= over_reg | quo_reg[frs_pkg::OUT_W-1];
        end
    end

    assign done     = done_reg;
    assign quotient = over_reg ? '1 : quo_reg;

endmodule

// ===== rtl/frame_rate_statistics_unit.sv =====
// Channel   | Signals                                   | Dir | Notes
// input     | in_valid, in_ready, cmd, elapsed_us       | in  | one transaction per command
// result    | out_valid, out_ready, average_fps, ...    | out | one transaction per period end
// config    | cfg_write_en, cfg_write_data              | in  | ideal_frame_us, no wait
//
// A frame event runs two scaled-rate divisions on the shared one-bit-per-cycle divider
// before the next acceptance; a period end runs four divisions (average, minimum,
// maximum, jitter) before its report is ready; a clear leaves the sequencer idle.
// in_ready is high only while the sequencer is idle. A finished report waits in
// the output register; the next report holds in its last state until that slot frees.
// Reset (rst_n, async low) clears all statistics and restores the ideal frame time.
module frame_rate_statistics_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [frs_pkg::CMD_W-1:0]       cmd,
    input  logic [frs_pkg::FRAME_W-1:0]     elapsed_us,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [frs_pkg::OUT_W-1:0]       average_fps,
    output logic [frs_pkg::OUT_W-1:0]       minimum_fps,
    output logic [frs_pkg::OUT_W-1:0]       maximum_fps,
    output logic [frs_pkg::OUT_W-1:0]       jitter_fps,
    input  logic                            cfg_write_en,
    input  logic [frs_pkg::IDEAL_W-1:0]     cfg_write_data
);

    frs_pkg::state_t               state_reg;
    logic [frs_pkg::IDEAL_W-1:0]   ideal_reg;
    logic                          seen_reg;
    logic [frs_pkg::COUNT_W-1:0]   count_reg;
    logic [frs_pkg::SUM_W-1:0]     sum_reg;
    logic [frs_pkg::FRAME_W-1:0]   shortest_reg;
    logic [frs_pkg::FRAME_W-1:0]   longest_reg;
    logic [frs_pkg::JIT_W-1:0]     jitter_reg;
    logic [frs_pkg::FRAME_W-1:0]   frame_reg;
    logic [frs_pkg::OUT_W-1:0]     rate_a_reg;
    logic [frs_pkg::PROD_W-1:0]    prod_reg;
    logic [frs_pkg::OUT_W-1:0]     avg_reg;
    logic [frs_pkg::OUT_W-1:0]     min_reg;
    logic [frs_pkg::OUT_W-1:0]     max_reg;
    logic [frs_pkg::OUT_W-1:0]     jit_reg;
    logic                          out_valid_reg;
    logic [frs_pkg::OUT_W-1:0]     avg_out_reg;
    logic [frs_pkg::OUT_W-1:0]     min_out_reg;
    logic [frs_pkg::OUT_W-1:0]     max_out_reg;
    logic [frs_pkg::OUT_W-1:0]     jit_out_reg;

    frs_pkg::div_req_t             div_req;
    logic                          div_done;
    logic [frs_pkg::OUT_W-1:0]     div_q;

    logic                          accept;
    logic [frs_pkg::IDEAL_W-1:0]   ideal_eff;
    logic [frs_pkg::FRAME_W-1:0]   frame_val;
    logic [frs_pkg::SUM_W:0]       sum_wide;
    logic [frs_pkg::OUT_W-1:0]     term;
    logic [frs_pkg::JIT_W:0]       jit_wide;
    logic                          slot_free;
    logic                          publish;

    assign in_ready  = (state_reg == frs_pkg::ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign publish   = (state_reg == frs_pkg::ST_DONE) && slot_free;

    // an ideal time of zero counts as one microsecond
    assign ideal_eff = (ideal_reg == '0) ? frs_pkg::IDEAL_W'(1) : ideal_reg;

    // first frame after reset takes the ideal time; others are raised to at least one
    always_comb
    begin
        if (!seen_reg)
            frame_val = frs_pkg::FRAME_W'(ideal_eff);
        else if (elapsed_us == '0)
            frame_val = frs_pkg::FRAME_W'(1);
        else
            frame_val = elapsed_us;
    end

    assign sum_wide = {1'b0, sum_reg} + (frs_pkg::SUM_W+1)'(frame_val);
    assign term     = (rate_a_reg > div_q) ? rate_a_reg - div_q : div_q - rate_a_reg;
    assign jit_wide = {1'b0, jitter_reg} + (frs_pkg::JIT_W+1)'(term);

    // start on frame accept or in ST_MUL, else as the previous division finishes
    always_comb
    begin
        div_req         = '0;
        div_req.steps   = frs_pkg::RATE_STEPS;
        div_req.numer   = frs_pkg::RATE_NUM_AL;
        case (state_reg)
            frs_pkg::ST_IDLE:
            begin
                div_req.start   = accept && (cmd == frs_pkg::CMD_FRAME);
                div_req.divisor = frs_pkg::DIV_W'(ideal_eff);
            end
            frs_pkg::ST_WAIT_A:
            begin
                div_req.start   = div_done;
                div_req.divisor = frs_pkg::DIV_W'(frame_reg);
            end
            frs_pkg::ST_MUL:
            begin
                div_req.start   = 1'b1;
                div_req.numer   = {prod_reg, frs_pkg::FRAC_BITS'(0)};
                div_req.divisor = sum_reg;
                div_req.steps   = frs_pkg::FULL_STEPS;
            end
            frs_pkg::ST_WAIT_AVG:
            begin
                div_req.start   = div_done;
                div_req.divisor = frs_pkg::DIV_W'(longest_reg);
            end
            frs_pkg::ST_WAIT_MIN:
            begin
                div_req.start   = div_done;
                div_req.divisor = frs_pkg::DIV_W'(shortest_reg);
            end
            frs_pkg::ST_WAIT_MAX:
            begin
                div_req.start   = div_done;
                div_req.numer   = frs_pkg::NUM_W'(jitter_reg);
                div_req.divisor = frs_pkg::DIV_W'(count_reg);
                div_req.steps   = frs_pkg::FULL_STEPS;
            end
            default:
            begin
                div_req.start   = 1'b0;
            end
        endcase
    end

    frs_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= frs_pkg::ST_IDLE;
            ideal_reg     <= frs_pkg::IDEAL_RESET;
            seen_reg      <= 1'b0;
            count_reg     <= '0;
            sum_reg       <= '0;
            shortest_reg  <= '1;
            longest_reg   <= '0;
            jitter_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
                ideal_reg <= cfg_write_data;
            // a new report takes the slot; otherwise drop the one just taken
            if (publish)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                frs_pkg::ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (cmd == frs_pkg::CMD_FRAME)
                        begin
                            // update the cheap statistics now, jitter after divisions
                            seen_reg <= 1'b1;
                            if (count_reg != '1)
                                count_reg <= count_reg + 1'b1;
                            sum_reg <= sum_wide[frs_pkg::SUM_W] ? '1
                                                                : sum_wide[frs_pkg::SUM_W-1:0];
                            if (frame_val < shortest_reg)
                                shortest_reg <= frame_val;
                            if (frame_val > longest_reg)
                                longest_reg <= frame_val;
                            state_reg <= frs_pkg::ST_WAIT_A;
                        end
                        else if (cmd == frs_pkg::CMD_REPORT)
                        begin
                            state_reg <= frs_pkg::ST_MUL;
                        end
                        else if (cmd == frs_pkg::CMD_CLEAR)
                        begin
                            count_reg    <= '0;
                            sum_reg      <= '0;
                            shortest_reg <= '1;
                            longest_reg  <= '0;
                            jitter_reg   <= '0;
                        end
                    end
                end
                frs_pkg::ST_WAIT_A:
                begin
                    if (div_done)
                        state_reg <= frs_pkg::ST_WAIT_B;
                end
                frs_pkg::ST_WAIT_B:
                begin
                    if (div_done)
                    begin
                        jitter_reg <= jit_wide[frs_pkg::JIT_W] ? '1
                                                               : jit_wide[frs_pkg::JIT_W-1:0];
                        state_reg  <= frs_pkg::ST_IDLE;
                    end
                end
                frs_pkg::ST_MUL:
                begin
                    state_reg <= frs_pkg::ST_WAIT_AVG;
                end
                frs_pkg::ST_WAIT_AVG:
                begin
                    if (div_done)
                        state_reg <= frs_pkg::ST_WAIT_MIN;
                end
                frs_pkg::ST_WAIT_MIN:
                begin
                    if (div_done)
                        state_reg <= frs_pkg::ST_WAIT_MAX;
                end
                frs_pkg::ST_WAIT_MAX:
                begin
                    if (div_done)
                        state_reg <= frs_pkg::ST_WAIT_JIT;
                end
                frs_pkg::ST_WAIT_JIT:
                begin
                    if (div_done)
                        state_reg <= frs_pkg::ST_DONE;
                end
                frs_pkg::ST_DONE:
                begin
                    // hold until the output slot frees, then publish and clear
                    if (slot_free)
                    begin
                        count_reg     <= '0;
                        sum_reg       <= '0;
                        shortest_reg  <= '1;
                        longest_reg   <= '0;
                        jitter_reg    <= '0;
                        state_reg     <= frs_pkg::ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= frs_pkg::ST_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept && (cmd == frs_pkg::CMD_FRAME))
            frame_reg <= frame_val;
        if ((state_reg == frs_pkg::ST_WAIT_A) && div_done)
            rate_a_reg <= div_q;
        if (accept && (cmd == frs_pkg::CMD_REPORT))
            prod_reg <= frs_pkg::PROD_W'(count_reg) * frs_pkg::PROD_W'(frs_pkg::MICROS_PER_SEC);
        if ((state_reg == frs_pkg::ST_WAIT_AVG) && div_done)
            avg_reg <= (sum_reg == '0) ? '0 : div_q;
        if ((state_reg == frs_pkg::ST_WAIT_MIN) && div_done)
            min_reg <= (longest_reg == '0) ? '0 : div_q;
        if ((state_reg == frs_pkg::ST_WAIT_MAX) && div_done)
            max_reg <= (longest_reg == '0) ? '0 : div_q;
        if ((state_reg == frs_pkg::ST_WAIT_JIT) && div_done)
            jit_reg <= (count_reg == '0) ? '0 : div_q;
        if (publish)
        begin
            avg_out_reg <= avg_reg;
            min_out_reg <= min_reg;
            max_out_reg <= max_reg;
            jit_out_reg <= jit_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign average_fps = avg_out_reg;
    assign minimum_fps = min_out_reg;
    assign maximum_fps = max_out_reg;
    assign jitter_fps  = jit_out_reg;

    a_frame_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd == frs_pkg::CMD_FRAME)) |=> (state_reg == frs_pkg::ST_WAIT_A))
        else $error("frame transaction did not start the divider");

    a_done_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg != frs_pkg::ST_IDLE))
        else $error("divider finished while sequencer idle");

    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (shortest_reg <= longest_reg))
        else $error("shortest frame above longest frame");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == frs_pkg::ST_DONE))
        else $error("result published outside report completion");

endmodule

// ===== tb/frame_rate_statistics_unit_tb.sv =====
module frame_rate_statistics_unit_tb;

    localparam longint unsigned RATE_MAX = 64'hF_FFFF_FFFF;
    localparam int              CYCLE_LIMIT = 3000000;
    localparam logic [frs_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [frs_pkg::CMD_W-1:0]   op;
        logic [frs_pkg::FRAME_W-1:0] elapsed;
    } command_t;

    typedef struct packed {
        logic [frs_pkg::OUT_W-1:0] avg;
        logic [frs_pkg::OUT_W-1:0] mn;
        logic [frs_pkg::OUT_W-1:0] mx;
        logic [frs_pkg::OUT_W-1:0] jit;
    } report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [frs_pkg::CMD_W-1:0] cmd = frs_pkg::CMD_FRAME;
    logic [frs_pkg::FRAME_W-1:0] elapsed_us = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [frs_pkg::OUT_W-1:0] average_fps, minimum_fps, maximum_fps, jitter_fps;
    logic cfg_write_en = 1'b0;
    logic [frs_pkg::IDEAL_W-1:0] cfg_write_data = '0;

    frame_rate_statistics_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .elapsed_us(elapsed_us),
        .out_valid(out_valid), .out_ready(out_ready),
        .average_fps(average_fps), .minimum_fps(minimum_fps),
        .maximum_fps(maximum_fps), .jitter_fps(jitter_fps),
        .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data)
    );

    always #2 clk = ~clk;

    // Predictor copy of the statistics block.
    logic [frs_pkg::IDEAL_W-1:0]   ideal_us;
    bit                            first_seen;
    logic [frs_pkg::COUNT_W-1:0]   frames;
    logic [frs_pkg::SUM_W-1:0]     total_us;
    logic [frs_pkg::FRAME_W-1:0]   shortest_us;
    logic [frs_pkg::FRAME_W-1:0]   longest_us;
    logic [frs_pkg::JIT_W-1:0]     jitter_acc;

    command_t pending_cmds[$];
    report_t  expected_reports[$];
    int       errors = 0;
    int       reports_seen = 0;
    int       cycles = 0;
    bit       quiet_phase = 1'b0;   // no idling on either side
    bit       hold_output = 1'b0;   // long receiver stall
    int       hold_count = 0;

    function automatic logic [63:0] fps_of(input logic [63:0] t);
        return (64'd1000000 << frs_pkg::FRAC_BITS) / t;
    endfunction

    function automatic logic [frs_pkg::OUT_W-1:0] clamp_rate(input logic [127:0] q);
        return (q > RATE_MAX) ? frs_pkg::OUT_W'(RATE_MAX) : q[frs_pkg::OUT_W-1:0];
    endfunction

    task automatic clear_stats();
        frames = '0;
        total_us = '0;
        shortest_us = '1;
        longest_us = '0;
        jitter_acc = '0;
    endtask

    // Advance the predicted statistics by one accepted transaction.
    task automatic predict_statistics(input command_t c);
        logic [63:0] ideal, frame, a, b, term;
        logic [64:0] wide;
        logic [127:0] num;
        report_t r;
        ideal = (ideal_us == 0) ? 64'd1 : 64'(ideal_us);
        if (c.op == frs_pkg::CMD_FRAME) begin
            if (!first_seen)
                frame = ideal;
            else
                frame = (c.elapsed == 0) ? 64'd1 : 64'(c.elapsed);
            first_seen = 1'b1;
            if (frames != '1)
                frames = frames + 1;
            wide = 65'(total_us) + 65'(frame);
            total_us = (wide > 65'(48'hFFFF_FFFF_FFFF)) ? '1 : wide[frs_pkg::SUM_W-1:0];
            if (frame < 64'(shortest_us))
                shortest_us = frame[frs_pkg::FRAME_W-1:0];
            if (frame > 64'(longest_us))
                longest_us = frame[frs_pkg::FRAME_W-1:0];
            a = fps_of(ideal);
            b = fps_of(frame);
            term = (a > b) ? a - b : b - a;
            wide = 65'(jitter_acc) + 65'(term);
            jitter_acc = wide[64] ? '1 : wide[63:0];
        end else if (c.op == frs_pkg::CMD_REPORT) begin
            r = '0;
            num = (128'd1000000 * 128'(frames)) << frs_pkg::FRAC_BITS;
            if (total_us != 0)
                r.avg = clamp_rate(num / 128'(total_us));
            if (longest_us != 0) begin
                r.mn = clamp_rate(128'(fps_of(64'(longest_us))));
                r.mx = clamp_rate(128'(fps_of(64'(shortest_us))));
            end
            if (frames != 0)
                r.jit = clamp_rate(128'(jitter_acc / 64'(frames)));
            expected_reports.push_back(r);
            clear_stats();
        end else if (c.op == frs_pkg::CMD_CLEAR) begin
            clear_stats();
        end
    endtask

    // Driver: present queued commands, idle at random outside the quiet phase.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (rst_n) begin
            if (!in_valid || in_ready) begin
                if (pending_cmds.size() > 0 && (quiet_phase || $urandom_range(99) >= 29)) begin
                    in_valid   <= 1'b1;
                    cmd        <= pending_cmds[0].op;
                    elapsed_us <= pending_cmds[0].elapsed;
                    void'(pending_cmds.pop_front());
                end else begin
                    in_valid <= 1'b0;
                end
            end
            if (in_valid && in_ready)
                predict_statistics('{op: cmd, elapsed: elapsed_us});
        end
    end

    // Receiver stall control lives in its own process, counted in cycles.
    always @(posedge clk) begin
        if (hold_output) begin
            out_ready  <= 1'b0;
            hold_count <= hold_count + 1;
        end else begin
            out_ready <= quiet_phase || ($urandom_range(99) >= 29);
        end
    end

    // Monitor: check each accepted report against the oldest prediction.
    always @(posedge clk) begin
        report_t exp_r;
        if (rst_n && out_valid && out_ready) begin
            reports_seen <= reports_seen + 1;
            if (expected_reports.size() == 0) begin
                $error("unexpected report avg=%0d", average_fps);
                errors++;
            end else begin
                exp_r = expected_reports.pop_front();
                if (average_fps !== exp_r.avg) begin
                    $error("average_fps expected %0d actual %0d", exp_r.avg, average_fps);
                    errors++;
                end
                if (minimum_fps !== exp_r.mn) begin
                    $error("minimum_fps expected %0d actual %0d", exp_r.mn, minimum_fps);
                    errors++;
                end
                if (maximum_fps !== exp_r.mx) begin
                    $error("maximum_fps expected %0d actual %0d", exp_r.mx, maximum_fps);
                    errors++;
                end
                if (jitter_fps !== exp_r.jit) begin
                    $error("jitter_fps expected %0d actual %0d", exp_r.jit, jitter_fps);
                    errors++;
                end
            end
        end
    end

    // Hard stop on a hang.
    always @(posedge clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic push_cmd(input logic [frs_pkg::CMD_W-1:0] op,
                            input logic [frs_pkg::FRAME_W-1:0] e);
        command_t c;
        c.op = op;
        c.elapsed = e;
        pending_cmds.push_back(c);
    endtask

    // Wait until every queued transaction is done and the block has gone quiet.
    task automatic drain();
        while (pending_cmds.size() > 0 || in_valid || expected_reports.size() > 0)
            @(posedge clk);
        // a trailing frame may still be in the divider
        repeat (400) @(posedge clk);
    endtask

    task automatic write_ideal(input logic [frs_pkg::IDEAL_W-1:0] v);
        @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        ideal_us = v;
    endtask

    // Random frame-rate period: mostly realistic frame times, some extremes.
    function automatic logic [frs_pkg::FRAME_W-1:0] pick_elapsed();
        case ($urandom_range(9))
            0: return frs_pkg::FRAME_W'($urandom_range(1, 0));
            1: return '1;
            2: return frs_pkg::FRAME_W'($urandom);
            default: return frs_pkg::FRAME_W'($urandom_range(40000, 4000));
        endcase
    endfunction

    initial begin
        int n, k, sent;
        ideal_us = frs_pkg::IDEAL_RESET;
        first_seen = 1'b0;
        clear_stats();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: report with no frames, first frame ignores elapsed, extremes.
        push_cmd(frs_pkg::CMD_REPORT, '0);
        push_cmd(frs_pkg::CMD_FRAME, 24'd5);
        push_cmd(frs_pkg::CMD_REPORT, '0);
        push_cmd(frs_pkg::CMD_FRAME, '0);
        push_cmd(frs_pkg::CMD_FRAME, '1);
        push_cmd(frs_pkg::CMD_FRAME, 24'h555555);
        push_cmd(frs_pkg::CMD_FRAME, 24'hAAAAAA);
        push_cmd(frs_pkg::CMD_REPORT, '0);
        push_cmd(frs_pkg::CMD_FRAME, 24'd16667);
        push_cmd(frs_pkg::CMD_CLEAR, '0);
        push_cmd(frs_pkg::CMD_REPORT, '0);
        push_cmd(CMD_UNUSED, 24'd7);
        push_cmd(frs_pkg::CMD_FRAME, 24'd1);
        push_cmd(frs_pkg::CMD_REPORT, '0);
        drain();

        // Extreme ideal settings, including zero treated as one.
        write_ideal('0);
        push_cmd(frs_pkg::CMD_FRAME, 24'd1000);
        push_cmd(frs_pkg::CMD_REPORT, '0);
        drain();
        write_ideal(frs_pkg::IDEAL_W'(1000000));
        push_cmd(frs_pkg::CMD_FRAME, '1);
        push_cmd(frs_pkg::CMD_FRAME, 24'd3);
        push_cmd(frs_pkg::CMD_REPORT, '0);
        drain();
        write_ideal(frs_pkg::IDEAL_W'('1));
        push_cmd(frs_pkg::CMD_FRAME, 24'd2);
        push_cmd(frs_pkg::CMD_REPORT, '0);
        drain();

        // Pressure: stall the receiver while reports pile up behind it.
        hold_output = 1'b1;
        for (k = 0; k < 6; k++) begin
            push_cmd(frs_pkg::CMD_FRAME, pick_elapsed());
            push_cmd(frs_pkg::CMD_REPORT, '0);
        end
        wait (hold_count >= 2000);
        hold_output = 1'b0;
        drain();

        // Random phases with changing ideal times; one phase has no idling.
        sent = 0;
        for (int phase = 0; phase < 8; phase++) begin
            write_ideal(phase == 0 ? frs_pkg::IDEAL_W'(1)
                                   : frs_pkg::IDEAL_W'($urandom_range(100000, 1)));
            quiet_phase = (phase == 3);
            while (sent < (phase + 1) * 200) begin
                n = $urandom_range(12, 1);
                for (k = 0; k < n; k++)
                    push_cmd(frs_pkg::CMD_FRAME, pick_elapsed());
                sent += n + 1;
                case ($urandom_range(19))
                    0: push_cmd(frs_pkg::CMD_CLEAR, frs_pkg::FRAME_W'($urandom));
                    1: push_cmd(CMD_UNUSED, frs_pkg::FRAME_W'($urandom));
                    default: push_cmd(frs_pkg::CMD_REPORT, frs_pkg::FRAME_W'($urandom));
                endcase
            end
            drain();
        end
        quiet_phase = 1'b0;

        $display("covered %0d reports over frame, report, clear and unused commands,",
                 reports_seen);
        $display("ideal frame times from 0 to full scale, and a long output stall");
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/frs_pkg.sv
rtl/frs_div.sv
rtl/frame_rate_statistics_unit.sv
tb/frame_rate_statistics_unit_tb.sv
